### rtl/core/qmr_pkg.sv
// ----------------------------------------------------------------------------
// qmr_pkg - shared constants for the quadratic root solver
// Default data format, the epsilon register layout and its reset value.
// ----------------------------------------------------------------------------
package qmr_pkg;

  // Default fixed-point format (signed Q16.16)
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Epsilon threshold register
  localparam int unsigned            EPS_WIDTH = 31;
  localparam logic [EPS_WIDTH-1:0]   EPS_RESET = EPS_WIDTH'(7);

endpackage

### rtl/core/qmr_if.sv
// ----------------------------------------------------------------------------
// qmr_if - valid/ready channels of the quadratic root solver
// Coefficient input, root result output and epsilon write channel.
// ----------------------------------------------------------------------------
interface qmr_in_if #(
  parameter int unsigned DATA_WIDTH = qmr_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;
  logic signed [DATA_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qmr_out_if #(
  parameter int unsigned DATA_WIDTH = qmr_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [DATA_WIDTH-1:0] chosen_root;
  logic signed [DATA_WIDTH-1:0] near_root;
  logic signed [DATA_WIDTH-1:0] far_root;
  logic                         saturated;

  modport source (output valid, hit, chosen_root, near_root, far_root, saturated,
                  input ready);
  modport sink   (input valid, hit, chosen_root, near_root, far_root, saturated,
                  output ready);
endinterface

interface qmr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [qmr_pkg::EPS_WIDTH-1:0]  epsilon;

  modport source (output valid, epsilon, input ready);
  modport sink   (input valid, epsilon, output ready);
endinterface

### rtl/core/qmr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qmr_sqrt_cell - one digit cell of the square root chain
// Resolves one root bit per cell (restoring, two radicand bits per step).
// ----------------------------------------------------------------------------
module qmr_sqrt_cell #(
  parameter int unsigned SQ = 33,
  parameter int unsigned PW = 65
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*SQ-1:0] rad_i,
  input  logic [SQ+1:0]   rem_i,
  input  logic [SQ-1:0]   root_i,
  input  logic [PW-1:0]   side_i,
  output logic            valid_o,
  output logic [2*SQ-1:0] rad_o,
  output logic [SQ+1:0]   rem_o,
  output logic [SQ-1:0]   root_o,
  output logic [PW-1:0]   side_o
);

  logic [SQ+1:0]   rs;
  logic [SQ+1:0]   trial;
  logic            ge;
  logic [2*SQ-1:0] rad_d;
  logic [SQ+1:0]   rem_d;
  logic [SQ-1:0]   root_d;

  // trial subtract of (4*root + 1)
  always_comb begin
    rs     = {rem_i[SQ-1:0], rad_i[2*SQ-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rs >= trial);
    rem_d  = ge ? (rs - trial) : rs;
    root_d = {root_i[SQ-2:0], ge};
    rad_d  = {rad_i[2*SQ-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

### rtl/core/qmr_div_cell.sv
// ----------------------------------------------------------------------------
// qmr_div_cell - one bit cell of the restoring divider chain
// Shifts in one dividend bit, compares with the divisor, emits one quotient bit.
// ----------------------------------------------------------------------------
module qmr_div_cell #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 49,
  parameter int unsigned PW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW:0]   den_i,
  input  logic [DW:0]   rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] num_o,
  output logic [DW:0]   den_o,
  output logic [DW:0]   rem_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] side_o
);

  logic [DW+1:0] rs;
  logic [DW+1:0] diff;
  logic          ge;

  // partial remainder step
  always_comb begin
    rs   = {rem_i, num_i[QW-1]};
    diff = rs - {1'b0, den_i};
    ge   = (rs >= {1'b0, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= {num_i[QW-2:0], 1'b0};
      den_o  <= den_i;
      rem_o  <= ge ? diff[DW:0] : rs[DW:0];
      quo_o  <= {quo_i[QW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

### rtl/core/quadratic_min_positive_root_top.sv
// ----------------------------------------------------------------------------
// quadratic_min_positive_root_top - nearest positive root of a quadratic
// Discriminant, square root chain, two divider chains and root selection.
// ----------------------------------------------------------------------------
// Accepts one coefficient transaction per cycle while the pipeline is not
// halted and returns one result transaction per input, in order. It has
// three front stages (abs, the two 32x32 products at Q16.16, discriminant),
// one square root cell per root bit, a numerator stage, one divider cell per
// quotient bit and the output register. The whole pipeline advances together;
// it halts only while the output register holds an untaken result and the
// last divider stage is full. Epsilon is written through the config channel
// (always ready) by the user only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module quadratic_min_positive_root_top #(
  parameter int unsigned DATA_WIDTH = qmr_pkg::DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = qmr_pkg::FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qmr_in_if.sink    in_i,
  qmr_out_if.source out_o,
  qmr_cfg_if.sink   cfg_i
);
  import qmr_pkg::*;

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned DWD = 2 * DW + 1;
  localparam int unsigned SQ  = DW + 1;
  localparam int unsigned RW  = 2 * SQ;
  localparam int unsigned QW  = DW + 1 + FB;
  localparam int unsigned TW  = (DWD > EPS_WIDTH + FB) ? DWD : EPS_WIDTH + FB;
  localparam int unsigned XW  = DW + 32;
  localparam int unsigned SPW = 2 * DW + 1;
  localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}} << FB;
  localparam logic [QW-1:0] LIM_POS   = QW'({1'b0, {(DW-1){1'b1}}});
  localparam logic [QW-1:0] LIM_NEG   = QW'({1'b1, {(DW-1){1'b0}}});

  // --------------------------------------------------------------------------
  // Epsilon register and pipeline advance
  // --------------------------------------------------------------------------
  logic [EPS_WIDTH-1:0] eps_q;
  logic                 en;
  logic                 load_out;
  logic                 last_valid;
  logic                 out_valid_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_i.valid) begin
      eps_q <= cfg_i.epsilon;
    end
  end

  assign load_out   = !out_valid_q || out_o.ready;
  assign en         = load_out || !last_valid;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Stage A: magnitudes and signs
  // --------------------------------------------------------------------------
  logic          va_q;
  logic [DW-1:0] ma_q, mb_q, mc_q;
  logic [DW-1:0] a_a_q, b_a_q;
  logic          aneg_a_q, cneg_a_q, anz_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q     <= in_i.coef_a[DW-1] ? DW'(-in_i.coef_a) : DW'(in_i.coef_a);
      mb_q     <= in_i.coef_b[DW-1] ? DW'(-in_i.coef_b) : DW'(in_i.coef_b);
      mc_q     <= in_i.coef_c[DW-1] ? DW'(-in_i.coef_c) : DW'(in_i.coef_c);
      a_a_q    <= in_i.coef_a;
      b_a_q    <= in_i.coef_b;
      aneg_a_q <= in_i.coef_a[DW-1];
      cneg_a_q <= in_i.coef_c[DW-1];
      anz_a_q  <= (in_i.coef_a != '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: b*b and a*c
  // --------------------------------------------------------------------------
  logic            vb_q;
  logic [2*DW-1:0] bb_q, ac_q;
  logic [DW-1:0]   a_b_q, b_b_q;
  logic            diff_b_q, anz_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb_q     <= mb_q * mb_q;
      ac_q     <= ma_q * mc_q;
      a_b_q    <= a_a_q;
      b_b_q    <= b_a_q;
      diff_b_q <= aneg_a_q ^ cneg_a_q;
      anz_b_q  <= anz_a_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: discriminant and threshold test
  // --------------------------------------------------------------------------
  logic           vc_q;
  logic [DWD-1:0] d_q;
  logic [DW-1:0]  a_c_q, b_c_q;
  logic           hit_c_q;
  logic [DWD-1:0] bb_x, ac4, d_d;
  logic [TW-1:0]  th;
  logic           d_ok;

  always_comb begin
    bb_x = {1'b0, bb_q};
    ac4  = {ac_q[2*DW-2:0], 2'b00};
    d_ok = diff_b_q || (bb_x >= ac4);
    d_d  = diff_b_q ? (bb_x + ac4) : (bb_x - ac4);
    th   = TW'(eps_q) << FB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= d_d;
      a_c_q   <= a_b_q;
      b_c_q   <= b_b_q;
      hit_c_q <= anz_b_q && d_ok && (TW'(d_d) > th);
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain: one cell per root bit
  // --------------------------------------------------------------------------
  logic          sq_v    [0:SQ];
  logic [RW-1:0] sq_rad  [0:SQ];
  logic [SQ+1:0] sq_rem  [0:SQ];
  logic [SQ-1:0] sq_root [0:SQ];
  logic [SPW-1:0] sq_side [0:SQ];

  assign sq_v[0]    = vc_q;
  assign sq_rad[0]  = {1'b0, d_q};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {hit_c_q, a_c_q, b_c_q};

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    qmr_sqrt_cell #(
      .SQ (SQ),
      .PW (SPW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_v[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage E: numerators -b -/+ s, divisor 2|a|, quotient signs
  // --------------------------------------------------------------------------
  logic          ve_q;
  logic [QW-1:0] num0_q, num1_q;
  logic [DW:0]   den_q;
  logic          hit_e_q, neg0_q, neg1_q;
  logic [DW-1:0] a_e, b_e, ma_e;
  logic          hit_e;
  logic [DW+1:0] bx, sx, n0, n1, m0, m1;

  always_comb begin
    {hit_e, a_e, b_e} = sq_side[SQ];
    bx   = {{2{b_e[DW-1]}}, b_e};
    sx   = {1'b0, sq_root[SQ]};
    n0   = -bx - sx;
    n1   = -bx + sx;
    m0   = n0[DW+1] ? -n0 : n0;
    m1   = n1[DW+1] ? -n1 : n1;
    ma_e = a_e[DW-1] ? -a_e : a_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num0_q  <= {m0[DW:0], {FB{1'b0}}};
      num1_q  <= {m1[DW:0], {FB{1'b0}}};
      den_q   <= {ma_e, 1'b0};
      hit_e_q <= hit_e;
      neg0_q  <= n0[DW+1] ^ a_e[DW-1];
      neg1_q  <= n1[DW+1] ^ a_e[DW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Divider chains: one cell per quotient bit, near and far root side by side
  // --------------------------------------------------------------------------
  logic          d0_v   [0:QW];
  logic [QW-1:0] d0_num [0:QW];
  logic [DW:0]   d0_den [0:QW];
  logic [DW:0]   d0_rem [0:QW];
  logic [QW-1:0] d0_quo [0:QW];
  logic [1:0]    d0_side [0:QW];
  logic          d1_v   [0:QW];
  logic [QW-1:0] d1_num [0:QW];
  logic [DW:0]   d1_den [0:QW];
  logic [DW:0]   d1_rem [0:QW];
  logic [QW-1:0] d1_quo [0:QW];
  logic [0:0]    d1_side [0:QW];

  assign d0_v[0]    = ve_q;
  assign d0_num[0]  = num0_q;
  assign d0_den[0]  = den_q;
  assign d0_rem[0]  = '0;
  assign d0_quo[0]  = '0;
  assign d0_side[0] = {hit_e_q, neg0_q};
  assign d1_v[0]    = ve_q;
  assign d1_num[0]  = num1_q;
  assign d1_den[0]  = den_q;
  assign d1_rem[0]  = '0;
  assign d1_quo[0]  = '0;
  assign d1_side[0] = neg1_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qmr_div_cell #(
      .DW (DW),
      .QW (QW),
      .PW (2)
    ) u_near (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d0_v[k]),
      .num_i   (d0_num[k]),
      .den_i   (d0_den[k]),
      .rem_i   (d0_rem[k]),
      .quo_i   (d0_quo[k]),
      .side_i  (d0_side[k]),
      .valid_o (d0_v[k+1]),
      .num_o   (d0_num[k+1]),
      .den_o   (d0_den[k+1]),
      .rem_o   (d0_rem[k+1]),
      .quo_o   (d0_quo[k+1]),
      .side_o  (d0_side[k+1])
    );

    qmr_div_cell #(
      .DW (DW),
      .QW (QW),
      .PW (1)
    ) u_far (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d1_v[k]),
      .num_i   (d1_num[k]),
      .den_i   (d1_den[k]),
      .rem_i   (d1_rem[k]),
      .quo_i   (d1_quo[k]),
      .side_i  (d1_side[k]),
      .valid_o (d1_v[k+1]),
      .num_o   (d1_num[k+1]),
      .den_o   (d1_den[k+1]),
      .rem_o   (d1_rem[k+1]),
      .quo_o   (d1_quo[k+1]),
      .side_o  (d1_side[k+1])
    );
  end

  assign last_valid = d0_v[QW] & d1_v[QW];

  // --------------------------------------------------------------------------
  // Saturation, sign and root selection
  // --------------------------------------------------------------------------
  logic          hit_f, neg0_f, neg1_f;
  logic [QW-1:0] lim0, lim1;
  logic          sat0, sat1;
  logic [DW-1:0] mag0, mag1, t0, t1;
  logic [XW-1:0] t0x, t1x, epsx;
  logic          pick0;

  always_comb begin
    {hit_f, neg0_f} = d0_side[QW];
    neg1_f = d1_side[QW][0];
    lim0   = neg0_f ? LIM_NEG : LIM_POS;
    lim1   = neg1_f ? LIM_NEG : LIM_POS;
    sat0   = d0_quo[QW] > lim0;
    sat1   = d1_quo[QW] > lim1;
    mag0   = sat0 ? lim0[DW-1:0] : d0_quo[QW][DW-1:0];
    mag1   = sat1 ? lim1[DW-1:0] : d1_quo[QW][DW-1:0];
    t0     = neg0_f ? -mag0 : mag0;
    t1     = neg1_f ? -mag1 : mag1;
    t0x    = {{32{t0[DW-1]}}, t0};
    t1x    = {{32{t1[DW-1]}}, t1};
    epsx   = {{(XW-EPS_WIDTH){1'b0}}, eps_q};
    pick0  = (($signed(t1x) < $signed(epsx)) || ($signed(t0x) < $signed(t1x)))
             && ($signed(t0x) > $signed(epsx));
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic          hit_q, sat_q;
  logic [DW-1:0] chosen_q, near_q, far_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && last_valid) begin
      hit_q    <= hit_f;
      sat_q    <= hit_f && (sat0 || sat1);
      near_q   <= hit_f ? t0 : MINUS_ONE;
      far_q    <= hit_f ? t1 : MINUS_ONE;
      chosen_q <= hit_f ? (pick0 ? t0 : t1) : MINUS_ONE;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = hit_q;
  assign out_o.saturated   = sat_q;
  assign out_o.near_root   = near_q;
  assign out_o.far_root    = far_q;
  assign out_o.chosen_root = chosen_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_miss_minus_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hit_q |-> near_q == MINUS_ONE && far_q == MINUS_ONE
                               && chosen_q == MINUS_ONE)
    else $error("no-hit result carries a root other than -1.0");

  a_chosen_is_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> chosen_q == near_q || chosen_q == far_q)
    else $error("chosen root matches neither root");

  a_sat_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sat_q |-> hit_q)
    else $error("saturation flagged without a hit");

  a_chains_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d0_v[QW] == d1_v[QW])
    else $error("divider chains out of step");

endmodule

### bench/tb_quadratic_min_positive_root_top.sv
// ----------------------------------------------------------------------------
// tb_quadratic_min_positive_root_top - quadratic root solver testbench
// Drives coefficient transactions in random bursts, stalls the result side on
// its own pattern, predicts each result from an independent model of the
// discriminant, floor square root and saturating divisions, and compares
// every field in order. Epsilon is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_quadratic_min_positive_root_top;
  import qmr_pkg::*;

  localparam int unsigned LATENCY   = 3 + (DATA_WIDTH + 1) + 1 + (DATA_WIDTH + 1 + FRAC_BITS) + 1;
  localparam longint      CYCLE_CAP = 400000;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [EPS_WIDTH-1:0] eps_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } coefs_t;

  typedef struct packed {
    logic  hit;
    word_t chosen;
    word_t near;
    word_t far;
    logic  sat;
  } roots_t;

  logic clk_i;
  logic rst_ni;

  qmr_in_if  in_if ();
  qmr_out_if out_if ();
  qmr_cfg_if cfg_if ();

  quadratic_min_positive_root_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  coefs_t pending_coefs[$];
  roots_t expected_roots[$];
  eps_t   cur_eps;
  bit     failed;
  bit     hold_sender;
  bit     in_taken;
  longint cycle_count;
  int     burst_left;
  int     gap_left;
  int     stall_mode;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor square root of a 66-bit discriminant
  function automatic logic [63:0] floor_sqrt(logic [65:0] d);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int k = 33; k >= 0; k--) begin
      t  = r | (64'd1 << k);
      sq = t * t;
      if (sq <= {62'd0, d}) r = t;
    end
    return r;
  endfunction

  // Signed quotient num*2^FRAC/den, truncated toward zero, saturated
  function automatic word_t sat_div(logic signed [67:0] num, logic signed [67:0] den,
                                    inout logic sat);
    logic          neg;
    logic [67:0]   mn;
    logic [67:0]   md;
    logic [127:0]  q;
    logic [127:0]  lim;
    neg = (num < 0) != (den < 0);
    mn  = num < 0 ? -num : num;
    md  = den < 0 ? -den : den;
    q   = ({60'd0, mn} << FRAC_BITS) / {60'd0, md};
    lim = neg ? (128'd1 << (DATA_WIDTH - 1)) : (128'd1 << (DATA_WIDTH - 1)) - 1;
    if (q > lim) begin
      q   = lim;
      sat = 1'b1;
    end
    return neg ? word_t'(-q) : word_t'(q);
  endfunction

  // Expected roots for one coefficient set under the current epsilon
  function automatic roots_t solve_roots(coefs_t cf, eps_t eps);
    roots_t             r;
    logic signed [67:0] a, b, c, d, s, t0, t1, e;
    logic               sat;
    a   = cf.a;
    b   = cf.b;
    c   = cf.c;
    e   = {37'd0, eps};
    sat = 1'b0;
    r.hit    = 1'b0;
    r.chosen = -(word_t'(1) <<< FRAC_BITS);
    r.near   = r.chosen;
    r.far    = r.chosen;
    if (a != 0) begin
      d = b * b - 4 * a * c;
      if (d > (e <<< FRAC_BITS)) begin
        s      = {4'd0, floor_sqrt(d[65:0])};
        r.near = sat_div(-b - s, 2 * a, sat);
        r.far  = sat_div(-b + s, 2 * a, sat);
        t0     = r.near;
        t1     = r.far;
        r.hit  = 1'b1;
        r.chosen = (((t1 < e) || (t0 < t1)) && (t0 > e)) ? r.near : r.far;
      end
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return word_t'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      3: return word_t'(1 << $urandom_range(0, 31)) ^ {DATA_WIDTH{$urandom_range(0, 1) == 1}};
      4: return word_t'($signed($urandom_range(0, 64)) - 32);
      default: return word_t'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
    endcase
  endfunction

  // Coefficients built from roots r0 and r1 so that most transactions hit
  function automatic coefs_t rand_coefs();
    coefs_t cf;
    longint a, r0, r1;
    if ($urandom_range(0, 3) == 0) begin
      cf.a = rand_word();
      cf.b = rand_word();
      cf.c = rand_word();
    end else begin
      a  = $signed($urandom_range(0, 512)) - 256;
      r0 = $signed($urandom_range(0, 4096)) - 1024;
      r1 = $signed($urandom_range(0, 4096)) - 1024;
      cf.a = word_t'(a <<< $urandom_range(0, 12));
      cf.b = word_t'(-a * (r0 + r1) <<< $urandom_range(0, 12));
      cf.c = word_t'(a * r0 * r1 + $signed($urandom_range(0, 255)) - 128);
    end
    return cf;
  endfunction

  task automatic push(word_t a, word_t b, word_t c);
    coefs_t cf;
    cf.a = a;
    cf.b = b;
    cf.c = c;
    pending_coefs.push_back(cf);
  endtask

  // Wait until pipeline drains, then write epsilon
  task automatic write_eps(eps_t v);
    wait (pending_coefs.size() == 0 && expected_roots.size() == 0);
    repeat (LATENCY + 2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.epsilon <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cur_eps = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic fill_random(int n);
    coefs_t cf;
    for (int i = 0; i < n; i++) begin
      cf = rand_coefs();
      pending_coefs.push_back(cf);
    end
  endtask

  // Stimulus and phases
  initial begin
    failed         = 1'b0;
    hold_sender    = 1'b0;
    cur_eps        = EPS_RESET;
    cfg_if.valid   = 1'b0;
    cfg_if.epsilon = '0;
    rst_ni         = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero a, negative and zero discriminant, extremes, saturation
    push(32'sh0, 32'sh0001_0000, 32'sh0001_0000);
    push(32'sh0001_0000, 32'sh0, 32'sh0001_0000);
    push(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
    push(32'sh0001_0000, 32'sh0, -32'sh0001_0000);
    push(32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000);
    push(-32'sh0001_0000, 32'sh0003_0000, -32'sh0002_0000);
    push(32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh0);
    push(32'sh0000_0001, 32'sh8000_0000, 32'sh0);
    push(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    push(-32'sh0000_0001, 32'sh0, 32'sh7FFF_FFFF);
    push(32'sh0000_0001, 32'sh0, 32'sh8000_0000);
    push(32'sh0001_0000, 32'sh0001_0000, -32'sh0006_0000);
    push(32'sh0001_0000, -32'sh0000_0010, 32'sh0);
    push(32'sh0001_0000, 32'sh0000_0010, 32'sh0);
    push(32'shFFFF_FFFF, 32'sh0, 32'sh0000_0001);

    // Sender holds until all results are back
    wait (pending_coefs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_roots.size() == 0);
    hold_sender = 1'b0;
    fill_random(400);

    write_eps('0);
    push(32'sh0001_0000, 32'sh0, 32'sh0);
    push(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
    fill_random(400);

    write_eps({EPS_WIDTH{1'b1}});
    push(32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh0);
    push(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    fill_random(200);

    write_eps(eps_t'(32'h0000_0100));
    fill_random(400);

    write_eps(eps_t'($urandom));
    fill_random(200);

    write_eps(EPS_RESET);
    fill_random(200);

    wait (pending_coefs.size() == 0 && expected_roots.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed) begin
      $display("tb_quadratic_min_positive_root_top OK");
    end else begin
      $display("tb_quadratic_min_positive_root_top NOT OK");
    end
    $finish;
  end

  // Driver: bursts and gaps, updates on the falling edge
  initial begin
    in_if.valid  = 1'b0;
    in_if.coef_a = '0;
    in_if.coef_b = '0;
    in_if.coef_c = '0;
    in_taken     = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    // Accepted transaction: record expectation and retire it
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_roots.push_back(solve_roots(pending_coefs[0], cur_eps));
      void'(pending_coefs.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // offered transaction still waiting: hold it
      in_if.valid <= 1'b1;
    end else if (hold_sender || pending_coefs.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left    <= gap_left - 1;
      in_if.valid <= 1'b0;
    end else begin
      in_if.valid  <= 1'b1;
      in_if.coef_a <= pending_coefs[0].a;
      in_if.coef_b <= pending_coefs[0].b;
      in_if.coef_c <= pending_coefs[0].c;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 60);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ~out_if.ready;
      endcase
    end
  end

  initial out_if.ready = 1'b0;

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1'b1;
      end else begin
        want = expected_roots.pop_front();
        if (out_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_if.hit);
          failed = 1'b1;
        end
        if (out_if.chosen_root !== want.chosen) begin
          $error("chosen_root: expected %0d, got %0d", want.chosen, out_if.chosen_root);
          failed = 1'b1;
        end
        if (out_if.near_root !== want.near) begin
          $error("near_root: expected %0d, got %0d", want.near, out_if.near_root);
          failed = 1'b1;
        end
        if (out_if.far_root !== want.far) begin
          $error("far_root: expected %0d, got %0d", want.far, out_if.far_root);
          failed = 1'b1;
        end
        if (out_if.saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, out_if.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // Cycle limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_quadratic_min_positive_root_top NOT OK");
      $finish;
    end
  end

endmodule
